// ===== rtl/gbi_pkg.sv =====
// gbi_pkg: shared types and constants for the GF(2) basis insert block.
// No dependencies; used by the interfaces, the reduction controller and the top level.
package gbi_pkg;

    // Fixed field widths of the channel payloads
    localparam int VEC_FIELD_W = 64;
    localparam int RANK_W      = 7;

    // Reduction controller states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_WALK
    } gbi_state_t;

endpackage

// ===== rtl/gbi_vec_if.sv =====
// gbi_vec_if: valid/ready channel carrying one vector to insert.
// Depends on gbi_pkg for the field width.
interface gbi_vec_if
    import gbi_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [VEC_FIELD_W-1:0] vector_in;

    modport source (output valid, output vector_in, input ready);
    modport sink   (input valid, input vector_in, output ready);
endinterface

// ===== rtl/gbi_res_if.sv =====
// gbi_res_if: valid/ready channel carrying one insertion result.
// Depends on gbi_pkg for the rank width.
interface gbi_res_if
    import gbi_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              was_added;
    logic [RANK_W-1:0] basis_rank;

    modport source (output valid, output was_added, output basis_rank, input ready);
    modport sink   (input valid, input was_added, input basis_rank, output ready);
endinterface

// ===== rtl/gf2_basis_insert.sv =====
// Channel   | Dir | Fields                        | Handshake
// vec_ch    | in  | vector_in[63:0]               | valid/ready
// res_ch    | out | was_added, basis_rank[6:0]    | valid/ready
//
// Each vector is accepted in the idle state, which also reads the top slot; the walk then
// visits one coordinate per cycle, set by the single read port of the pivot slot memory,
// but may hold on its final slot while a result waits. The walk ends early at the first
// set coordinate whose slot is empty; a dependent vector walks all.
// Reset empties every pivot slot at once through per-slot valid flags and zeroes the rank.
// A waiting result sits in an output register; the next vector is taken meanwhile, and
// the walk holds on its final slot only if the previous result is still untaken.
module gf2_basis_insert
    import gbi_pkg::*;
#(
    parameter int VEC_WIDTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    gbi_vec_if.sink   vec_ch,
    gbi_res_if.source res_ch
);

    localparam int IDX_W = $clog2(VEC_WIDTH);

    logic [IDX_W-1:0]     rd_addr;
    logic [VEC_WIDTH-1:0] rd_data;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [VEC_WIDTH-1:0] wr_data;

    // Reduction walk and result register
    gbi_reduce #(
        .VEC_WIDTH (VEC_WIDTH),
        .IDX_W     (IDX_W)
    ) u_reduce (
        .clk     (clk),
        .rst_n   (rst_n),
        .vec_ch  (vec_ch),
        .res_ch  (res_ch),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Pivot slot store
    gbi_slot_ram #(
        .VEC_WIDTH (VEC_WIDTH),
        .IDX_W     (IDX_W)
    ) u_slot_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

// ===== rtl/gbi_slot_ram.sv =====
// gbi_slot_ram: pivot slot store, one write and one registered read port per cycle.
// Per-slot valid flags make a never-written slot read as zero (empty) after reset.
module gbi_slot_ram #(
    parameter int VEC_WIDTH = 64,
    parameter int IDX_W     = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [IDX_W-1:0]     rd_addr,
    output logic [VEC_WIDTH-1:0] rd_data,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  logic [VEC_WIDTH-1:0] wr_data
);

    logic [VEC_WIDTH-1:0] mem [VEC_WIDTH];
    logic [VEC_WIDTH-1:0] slot_valid_reg;
    logic [VEC_WIDTH-1:0] rd_data_reg;
    logic                 rd_valid_reg;

    // Write and read the slot array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Track written slots and register the read's valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                slot_valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= slot_valid_reg[rd_addr];
        end
    end

    // Empty slots read as zero
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/gbi_reduce.sv =====
// gbi_reduce: walks one vector from its top coordinate down, one pivot slot per cycle,
// storing it in the first empty slot it hits. Depends on gbi_pkg and both channel interfaces.
module gbi_reduce
    import gbi_pkg::*;
#(
    parameter int VEC_WIDTH = 64,
    parameter int IDX_W     = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    gbi_vec_if.sink              vec_ch,
    gbi_res_if.source            res_ch,
    output logic [IDX_W-1:0]     rd_addr,
    input  logic [VEC_WIDTH-1:0] rd_data,
    output logic                 wr_en,
    output logic [IDX_W-1:0]     wr_addr,
    output logic [VEC_WIDTH-1:0] wr_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VEC_WIDTH - 1);

    gbi_state_t           state_reg, state_next;
    logic [VEC_WIDTH-1:0] v_reg, v_next;
    logic [IDX_W-1:0]     bit_reg, bit_next;
    logic [RANK_W-1:0]    rank_reg, rank_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 added_reg, added_next;
    logic [RANK_W-1:0]    out_rank_reg, out_rank_next;

    logic hit;
    logic store;
    logic done;
    logic can_emit;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rank_reg      <= rank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        v_reg        <= v_next;
        bit_reg      <= bit_next;
        added_reg    <= added_next;
        out_rank_reg <= out_rank_next;
    end

    assign hit      = v_reg[bit_reg];
    assign store    = hit && (rd_data == '0);
    assign done     = store || (bit_reg == '0);
    assign can_emit = !out_valid_reg || res_ch.ready;

    // Next state, slot accesses and result
    always_comb
    begin
        state_next     = state_reg;
        v_next         = v_reg;
        bit_next       = bit_reg;
        rank_next      = rank_reg;
        added_next     = added_reg;
        out_rank_next  = out_rank_reg;
        out_valid_next = out_valid_reg && !res_ch.ready;
        vec_ch.ready   = 1'b0;
        rd_addr        = LAST_IDX;
        wr_en          = 1'b0;
        wr_addr        = bit_reg;
        wr_data        = v_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                vec_ch.ready = 1'b1;
                if (vec_ch.valid)
                begin
                    v_next     = vec_ch.vector_in[VEC_WIDTH-1:0];
                    bit_next   = LAST_IDX;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (done)
                begin
                    if (can_emit)
                    begin
                        // Finish: store if the coordinate is set and its slot empty, post the result
                        wr_en          = store;
                        rank_next      = store ? rank_reg + RANK_W'(1) : rank_reg;
                        out_rank_next  = store ? rank_reg + RANK_W'(1) : rank_reg;
                        added_next     = store;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        // Hold: re-read the same slot until the result register frees
                        rd_addr = bit_reg;
                    end
                end
                else
                begin
                    // Advance: reduce by the held pivot if the coordinate is set, and move one coordinate down
                    v_next   = hit ? (v_reg ^ rd_data) : v_reg;
                    bit_next = bit_reg - IDX_W'(1);
                    rd_addr  = bit_reg - IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_ch.valid      = out_valid_reg;
    assign res_ch.was_added  = added_reg;
    assign res_ch.basis_rank = out_rank_reg;

endmodule

// ===== tb/tb_gf2_basis_insert.sv =====
// tb_gf2_basis_insert: self-checking testbench for the GF(2) basis insert block.
// Depends on gbi_pkg, gbi_vec_if, gbi_res_if and gf2_basis_insert from the rtl folder.
// A local GF(2) basis predicts was_added and basis_rank for every accepted vector.
module tb_gf2_basis_insert;
    import gbi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD = 12;
    localparam int          VEC_WIDTH  = 64;
    localparam int          DRAIN_WAIT = VEC_WIDTH + 16;
    localparam logic [VEC_FIELD_W-1:0] WIDTH_MASK =
        {VEC_FIELD_W{1'b1}} >> (VEC_FIELD_W - VEC_WIDTH);

    typedef struct packed {
        logic              was_added;
        logic [RANK_W-1:0] basis_rank;
    } insert_result_t;

    logic clk = 1'b0;
    logic rst_n;

    gbi_vec_if vec_ch ();
    gbi_res_if res_ch ();

    gf2_basis_insert #(
        .VEC_WIDTH (VEC_WIDTH)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .vec_ch (vec_ch),
        .res_ch (res_ch)
    );

    // Predicted basis and bookkeeping
    logic [VEC_FIELD_W-1:0] pivot_model [VEC_FIELD_W];
    logic [RANK_W-1:0]      rank_model;
    insert_result_t         pending_results [$];
    logic [VEC_FIELD_W-1:0] sent_history [$];
    int unsigned            error_count = 0;
    bit                     steady_mode = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Reduce one vector against the predicted basis, store it if it survives
    function automatic insert_result_t predict_insert(input logic [VEC_FIELD_W-1:0] vec);
        logic [VEC_FIELD_W-1:0] residue;
        insert_result_t         outcome;
        residue           = vec & WIDTH_MASK;
        outcome.was_added = 1'b0;
        for (int b = VEC_WIDTH - 1; b >= 0; b--)
        begin
            if (residue[b])
            begin
                if (pivot_model[b] == '0)
                begin
                    pivot_model[b]    = residue;
                    rank_model        = rank_model + 1'b1;
                    outcome.was_added = 1'b1;
                    break;
                end
                residue ^= pivot_model[b];
            end
        end
        outcome.basis_rank = rank_model;
        return outcome;
    endfunction

    // No gap half the time (always in steady mode), some short ones, a few long ones that can span a walk
    function automatic int unsigned draw_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady_mode || roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [VEC_FIELD_W-1:0] rand_vector();
        return {$urandom(), $urandom()};
    endfunction

    // XOR of earlier vectors: always in the span, so always dependent
    function automatic logic [VEC_FIELD_W-1:0] span_combo();
        logic [VEC_FIELD_W-1:0] acc;
        acc = '0;
        repeat ($urandom_range(1, 6))
            acc ^= sent_history[$urandom_range(0, sent_history.size() - 1)];
        return acc;
    endfunction

    function automatic logic [VEC_FIELD_W-1:0] sparse_vector();
        logic [VEC_FIELD_W-1:0] acc;
        acc = '0;
        repeat ($urandom_range(1, 3))
            acc[$urandom_range(0, VEC_FIELD_W - 1)] = 1'b1;
        return acc;
    endfunction

    // Blend of dependent combinations, fresh vectors of random height and odd cases
    function automatic logic [VEC_FIELD_W-1:0] pick_mixed_vector();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55 && sent_history.size() > 0)
            return span_combo();
        if (roll < 80)
            return rand_vector() >> $urandom_range(0, VEC_FIELD_W - 1);
        if (roll < 93)
            return sparse_vector();
        if (roll < 96)
            return '0;
        if (roll < 98)
            return '1;
        return rand_vector();
    endfunction

    // Offer one vector, hold it until accepted, then record the prediction
    task automatic send_vector(input logic [VEC_FIELD_W-1:0] vec);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            vec_ch.valid     <= 1'b0;
            vec_ch.vector_in <= rand_vector();
            repeat (gap) @(posedge clk);
        end
        vec_ch.valid     <= 1'b1;
        vec_ch.vector_in <= vec;
        @(posedge clk);
        while (!vec_ch.ready)
            @(posedge clk);
        pending_results = {pending_results, predict_insert(vec)};
        sent_history    = {sent_history, vec};
    endtask

    task automatic test_edge_vectors();
        logic [VEC_FIELD_W-1:0] directed [$];
        directed = '{
            64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001,
            64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
            64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001,
            64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
            64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0001_0000_0000,
            64'h7FFF_FFFF_FFFF_FFFE, 64'h0000_0000_0000_0000,
            64'h8000_0000_0000_0000, 64'hC000_0000_0000_0003
        };
        foreach (directed[i])
            send_vector(directed[i]);
    endtask

    task automatic test_span_fill(input int unsigned count);
        steady_mode = 1'b0;
        repeat (count)
            send_vector(pick_mixed_vector());
    endtask

    // Back-to-back vectors and an always-ready sink
    task automatic test_steady_stream(input int unsigned count);
        steady_mode = 1'b1;
        repeat (count)
            send_vector(pick_mixed_vector());
        steady_mode = 1'b0;
    endtask

    // One vector per coordinate, top down: leaves the basis full
    task automatic test_unit_sweep();
        for (int b = VEC_WIDTH - 1; b >= 0; b--)
            send_vector(64'h1 << b);
    endtask

    // Every vector must reduce to zero once the basis is full
    task automatic test_full_basis(input int unsigned count);
        repeat (count)
            send_vector(pick_mixed_vector());
    endtask

    task automatic finish_run();
        vec_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin : result_check
        insert_result_t want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: result with none predicted: was_added=%0b rank=%0d",
                             $realtime, res_ch.was_added, res_ch.basis_rank);
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_ch.was_added !== want.was_added ||
                    res_ch.basis_rank !== want.basis_rank)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: mismatch: was_added exp %0b got %0b, rank exp %0d got %0d",
                                 $realtime, want.was_added, res_ch.was_added,
                                 want.basis_rank, res_ch.basis_rank);
                end
            end
        end
    end

    // Result sink: bursts of ready broken by random stalls
    initial
    begin : sink_drive
        int unsigned gap;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            gap = draw_gap();
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        foreach (pivot_model[i])
            pivot_model[i] = '0;
        rank_model        = '0;
        rst_n            <= 1'b0;
        vec_ch.valid     <= 1'b0;
        vec_ch.vector_in <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_vectors();
        test_span_fill(450);
        test_steady_stream(150);
        test_unit_sweep();
        test_full_basis(470);
        finish_run();

        if (error_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
